// ===== design/madt_record_parser_defines.svh =====
// assertion macros for the interrupt-controller table parser
// no dependencies; included by files that carry concurrent checks
`ifndef MADT_RECORD_PARSER_DEFINES_SVH
`define MADT_RECORD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MADT_CHECK_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MADT_CHECK_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MADT_CHECK_NOW(name, clk, rstn, ante, cons, msg)
`define MADT_CHECK_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/madt_pkg.sv =====
// shared types, limits and codes of the interrupt-controller table parser
// no dependencies
package madt_pkg;

    localparam int MAX_CPUS    = 64;
    localparam int MAX_IOAPICS = 8;
    localparam int HOLD_BYTES  = 16;

    localparam int CPU_IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CPU_CNT_W = $clog2(MAX_CPUS + 1);
    localparam int IOA_CNT_W = $clog2(MAX_IOAPICS + 1);
    localparam int HOLD_IDX_W = $clog2(HOLD_BYTES);

    // record kinds on the result channel
    localparam logic [2:0] KIND_CPU    = 3'd0;
    localparam logic [2:0] KIND_IOAPIC = 3'd1;
    localparam logic [2:0] KIND_ISA    = 3'd2;
    localparam logic [2:0] KIND_LAPIC  = 3'd3;
    localparam logic [2:0] KIND_FINAL  = 3'd4;

    // status codes
    localparam logic [3:0] STAT_OK        = 4'd0;
    localparam logic [3:0] STAT_TRUNC_HDR = 4'd1;
    localparam logic [3:0] STAT_SHORT_LEN = 4'd2;
    localparam logic [3:0] STAT_OVERRUN   = 4'd3;
    localparam logic [3:0] STAT_ID_RANGE  = 4'd4;
    localparam logic [3:0] STAT_DUP_ID    = 4'd5;
    localparam logic [3:0] STAT_TOO_MANY  = 4'd6;
    localparam logic [3:0] STAT_OVR_WIDE  = 4'd7;
    localparam logic [3:0] STAT_NO_TOPO   = 4'd8;

    // record type bytes
    localparam logic [7:0] REC_LAPIC     = 8'd0;
    localparam logic [7:0] REC_IOAPIC    = 8'd1;
    localparam logic [7:0] REC_ISO       = 8'd2;
    localparam logic [7:0] REC_LAPIC_OVR = 8'd5;
    localparam logic [7:0] REC_X2APIC    = 8'd9;

    // minimum record lengths
    localparam logic [7:0] LEN_LAPIC     = 8'd8;
    localparam logic [7:0] LEN_IOAPIC    = 8'd12;
    localparam logic [7:0] LEN_ISO       = 8'd10;
    localparam logic [7:0] LEN_LAPIC_OVR = 8'd12;
    localparam logic [7:0] LEN_X2APIC    = 8'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_table;
    } madt_in_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  controller_id;
        logic [31:0] base_address;
        logic [31:0] interrupt_base;
        logic [3:0]  isa_source;
        logic [15:0] isa_flags;
        logic [3:0]  status;
        logic [6:0]  cpu_count;
        logic [3:0]  ioapic_count;
        logic        final_result;
    } madt_out_t;

    // record buffer write
    typedef struct packed {
        logic                  en;
        logic [HOLD_IDX_W-1:0] idx;
        logic [7:0]            data;
    } madt_buf_wr_t;

    // little-endian fields taken at fixed record offsets
    typedef struct packed {
        logic [31:0] word4;
        logic [31:0] word8;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [15:0] half8;
    } madt_fields_t;

    // id memory access
    typedef struct packed {
        logic                 rd_en;
        logic [CPU_IDX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [CPU_IDX_W-1:0] wr_addr;
        logic [7:0]           wr_data;
    } madt_ram_req_t;

endpackage

// ===== design/madt_record_parser.sv =====
// channel   | dir | handshake          | payload
// s_        | in  | s_valid / s_ready  | madt_in_t: one table body byte
// m_        | out | m_valid / m_ready  | madt_out_t: record or final status
// cfg_      | in  | cfg_wr_en          | header local APIC base, 32 bits
//
// a body byte is taken in the idle state and handled in a step state; a byte that closes
// a record adds a decode state and a result state, and a processor record also walks
// the id memory one entry per cycle. the final byte adds a status state.
// results wait in an output register while the next byte is taken.
// reset is synchronous, active low, and needs no clearing pass.
// top level, depends on madt_pkg, madt_rec_buf, madt_id_store and the defines header
`include "madt_record_parser_defines.svh"

module madt_record_parser
    import madt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  madt_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output madt_out_t   m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DECODE,
        ST_SEARCH,
        ST_ADD,
        ST_EMIT,
        ST_FINAL
    } state_t;

    state_t                state_reg, state_next;
    logic                  open_reg, open_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  eot_reg, eot_next;
    logic [7:0]            offset_reg, offset_next;
    logic [7:0]            type_reg, type_next;
    logic [7:0]            len_reg, len_next;
    logic [CPU_CNT_W-1:0]  cpus_reg, cpus_next;
    logic [IOA_CNT_W-1:0]  ioap_reg, ioap_next;
    logic [31:0]           lapic_reg, lapic_next;
    logic [3:0]            err_reg, err_next;
    logic [7:0]            cand_reg, cand_next;
    logic [CPU_IDX_W-1:0]  idx_reg, idx_next;
    madt_out_t             pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    madt_out_t             m_data_reg, m_data_next;
    logic [31:0]           cfg_lapic_reg, cfg_lapic_next;

    madt_buf_wr_t  buf_wr;
    madt_fields_t  fields;
    madt_ram_req_t ram_req;
    logic [7:0]    ram_rd_data;

    logic          out_free;
    logic          done_c;
    logic          proc_c;
    logic [31:0]   pid_c;
    logic [3:0]    fin_stat_c;
    state_t        after_c;

    madt_rec_buf u_rec_buf (
        .aclk   (aclk),
        .wr     (buf_wr),
        .fields (fields)
    );

    madt_id_store u_id_store (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign after_c  = eot_reg ? ST_FINAL : ST_IDLE;

    // processor candidate of a completed record
    always_comb begin
        proc_c = 1'b0;
        pid_c  = '0;
        case (type_reg)
            REC_LAPIC: begin
                if (len_reg >= LEN_LAPIC && fields.word4[1:0] != 2'b00) begin
                    proc_c = 1'b1;
                    pid_c  = {24'd0, fields.byte3};
                end
            end
            REC_X2APIC: begin
                if (len_reg >= LEN_X2APIC && fields.word8[1:0] != 2'b00) begin
                    proc_c = 1'b1;
                    pid_c  = fields.word4;
                end
            end
            default: begin
                proc_c = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (err_reg != STAT_OK) begin
            fin_stat_c = err_reg;
        end else if (cpus_reg == '0 || ioap_reg == '0 || lapic_reg == '0) begin
            fin_stat_c = STAT_NO_TOPO;
        end else begin
            fin_stat_c = STAT_OK;
        end
    end

    always_comb begin
        state_next     = state_reg;
        open_next      = open_reg;
        byte_next      = byte_reg;
        eot_next       = eot_reg;
        offset_next    = offset_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        cpus_next      = cpus_reg;
        ioap_next      = ioap_reg;
        lapic_next     = lapic_reg;
        err_next       = err_reg;
        cand_next      = cand_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        cfg_lapic_next = cfg_wr_en ? cfg_wr_data : cfg_lapic_reg;
        buf_wr         = '0;
        ram_req        = '0;
        done_c         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data.data_byte;
                    eot_next  = s_data.end_of_table;
                    // first byte of a table starts fresh
                    if (!open_reg) begin
                        open_next   = 1'b1;
                        cpus_next   = '0;
                        ioap_next   = '0;
                        err_next    = STAT_OK;
                        offset_next = '0;
                        lapic_next  = cfg_lapic_reg;
                    end
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (err_reg == STAT_OK) begin
                    if (offset_reg < 8'(HOLD_BYTES)) begin
                        buf_wr.en   = 1'b1;
                        buf_wr.idx  = offset_reg[HOLD_IDX_W-1:0];
                        buf_wr.data = byte_reg;
                    end
                    case (offset_reg)
                        8'd0: begin
                            type_next = byte_reg;
                            if (eot_reg) begin
                                err_next = STAT_TRUNC_HDR;
                            end
                        end
                        8'd1: begin
                            len_next = byte_reg;
                            if (byte_reg < 8'd2) begin
                                err_next = STAT_SHORT_LEN;
                            end else if (byte_reg == 8'd2) begin
                                done_c = 1'b1;
                            end else if (eot_reg) begin
                                err_next = STAT_OVERRUN;
                            end
                        end
                        default: begin
                            if ({1'b0, offset_reg} + 9'd1 == {1'b0, len_reg}) begin
                                done_c = 1'b1;
                            end else if (eot_reg) begin
                                err_next = STAT_OVERRUN;
                            end
                        end
                    endcase
                    if (done_c) begin
                        offset_next = '0;
                        state_next  = ST_DECODE;
                    end else begin
                        if (err_next == STAT_OK) begin
                            offset_next = offset_reg + 8'd1;
                        end
                        state_next = after_c;
                    end
                end else begin
                    state_next = after_c;
                end
            end
            ST_DECODE: begin
                pend_next  = '0;
                state_next = after_c;
                case (type_reg)
                    REC_IOAPIC: begin
                        if (len_reg >= LEN_IOAPIC && ioap_reg < IOA_CNT_W'(MAX_IOAPICS)) begin
                            ioap_next                = ioap_reg + 1'b1;
                            pend_next.record_kind    = KIND_IOAPIC;
                            pend_next.controller_id  = fields.byte2;
                            pend_next.base_address   = fields.word4;
                            pend_next.interrupt_base = fields.word8;
                            state_next               = ST_EMIT;
                        end
                    end
                    REC_ISO: begin
                        if (len_reg >= LEN_ISO && fields.byte2 == 8'd0
                                && fields.byte3 < 8'd16) begin
                            pend_next.record_kind    = KIND_ISA;
                            pend_next.interrupt_base = fields.word4;
                            pend_next.isa_source     = fields.byte3[3:0];
                            pend_next.isa_flags      = fields.half8;
                            state_next               = ST_EMIT;
                        end
                    end
                    REC_LAPIC_OVR: begin
                        if (len_reg >= LEN_LAPIC_OVR) begin
                            if (fields.word8 != '0) begin
                                err_next = STAT_OVR_WIDE;
                            end else begin
                                lapic_next             = fields.word4;
                                pend_next.record_kind  = KIND_LAPIC;
                                pend_next.base_address = fields.word4;
                                state_next             = ST_EMIT;
                            end
                        end
                    end
                    default: begin
                        pend_next = '0;
                    end
                endcase
                if (proc_c) begin
                    if (pid_c > 32'd255) begin
                        err_next = STAT_ID_RANGE;
                    end else begin
                        cand_next = pid_c[7:0];
                        if (cpus_reg == '0) begin
                            state_next = ST_ADD;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                            idx_next        = '0;
                            state_next      = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                // read data belongs to idx_reg; next address issued in the same cycle
                if (ram_rd_data == cand_reg) begin
                    err_next   = STAT_DUP_ID;
                    state_next = after_c;
                end else if (CPU_CNT_W'(idx_reg) + 1'b1 == cpus_reg) begin
                    state_next = ST_ADD;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            ST_ADD: begin
                if (cpus_reg >= CPU_CNT_W'(MAX_CPUS)) begin
                    err_next   = STAT_TOO_MANY;
                    state_next = after_c;
                end else begin
                    ram_req.wr_en           = 1'b1;
                    ram_req.wr_addr         = cpus_reg[CPU_IDX_W-1:0];
                    ram_req.wr_data         = cand_reg;
                    cpus_next               = cpus_reg + 1'b1;
                    pend_next               = '0;
                    pend_next.record_kind   = KIND_CPU;
                    pend_next.controller_id = cand_reg;
                    state_next              = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next               = pend_reg;
                    m_data_next.cpu_count     = 7'(cpus_reg);
                    m_data_next.ioapic_count  = 4'(ioap_reg);
                    state_next                = after_c;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next               = '0;
                    m_data_next.record_kind   = KIND_FINAL;
                    m_data_next.base_address  = lapic_reg;
                    m_data_next.status        = fin_stat_c;
                    m_data_next.cpu_count     = 7'(cpus_reg);
                    m_data_next.ioapic_count  = 4'(ioap_reg);
                    m_data_next.final_result  = 1'b1;
                    err_next                  = fin_stat_c;
                    open_next                 = 1'b0;
                    offset_next               = '0;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        eot_reg    <= eot_next;
        cand_reg   <= cand_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            offset_reg    <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            cpus_reg      <= '0;
            ioap_reg      <= '0;
            lapic_reg     <= '0;
            err_reg       <= STAT_OK;
            m_valid_reg   <= 1'b0;
            cfg_lapic_reg <= '0;
        end else begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            offset_reg    <= offset_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            cpus_reg      <= cpus_next;
            ioap_reg      <= ioap_next;
            lapic_reg     <= lapic_next;
            err_reg       <= err_next;
            m_valid_reg   <= m_valid_next;
            cfg_lapic_reg <= cfg_lapic_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`MADT_CHECK_NEXT(a_accept_steps, aclk, aresetn, s_valid && s_ready, state_reg == ST_STEP, "accepted item not stepped")
`MADT_CHECK_NOW(a_final_kind, aclk, aresetn, m_valid_reg && m_data_reg.final_result, m_data_reg.record_kind == KIND_FINAL, "final item with wrong kind")
`MADT_CHECK_NOW(a_record_ok, aclk, aresetn, m_valid_reg && !m_data_reg.final_result, m_data_reg.status == STAT_OK && m_data_reg.record_kind != KIND_FINAL, "record item carries status")
`MADT_CHECK_NOW(a_search_bounds, aclk, aresetn, state_reg == ST_SEARCH, cpus_reg != '0 && cpus_reg <= CPU_CNT_W'(MAX_CPUS), "id search outside held range")

endmodule

// ===== design/madt_rec_buf.sv =====
// record byte buffer: holds the leading bytes of the current record
// and presents its fixed-offset fields; uses madt_pkg
module madt_rec_buf
    import madt_pkg::*;
(
    input  logic         aclk,
    input  madt_buf_wr_t wr,
    output madt_fields_t fields
);

    logic [7:0] buf_mem [HOLD_BYTES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            buf_mem[wr.idx] <= wr.data;
        end
    end

    assign fields.word4 = {buf_mem[7], buf_mem[6], buf_mem[5], buf_mem[4]};
    assign fields.word8 = {buf_mem[11], buf_mem[10], buf_mem[9], buf_mem[8]};
    assign fields.byte2 = buf_mem[2];
    assign fields.byte3 = buf_mem[3];
    assign fields.half8 = {buf_mem[9], buf_mem[8]};

endmodule

// ===== design/madt_id_store.sv =====
// processor id memory: one write port, one read port, registered read data
// uses madt_pkg
module madt_id_store
    import madt_pkg::*;
(
    input  logic          aclk,
    input  madt_ram_req_t req,
    output logic [7:0]    rd_data
);

    logic [7:0] id_mem [MAX_CPUS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            id_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= id_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/madt_record_parser_tb.sv =====
// testbench for madt_record_parser: feeds table bodies one byte per item, runs a local
// parser model on every accepted byte and checks each result item field by field
// depends on madt_pkg and the madt_record_parser rtl
module madt_record_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import madt_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int TAIL_CYCLES     = MAX_CPUS + 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_BYTES    = 1150;
    localparam int MISMATCH_PRINTS = 40;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    madt_in_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    madt_out_t   m_data;

    madt_record_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // stimulus and traffic shaping
    madt_in_t   body_bytes[$];
    logic [7:0] table_body[$];
    int         rec_start;
    bit         src_idle, snk_idle;
    int         src_gap, sink_gap, hold_left;
    int         hold_asked, hold_served;
    bit         s_took, m_took;

    // local parser state
    madt_out_t   parsed_items[$];
    logic [31:0] hdr_lapic = '0;
    logic [31:0] lapic_now = '0;
    logic [7:0]  rec_off = '0, rec_type = '0, rec_len = '0;
    logic [7:0]  rec_buf [HOLD_BYTES] = '{default: '0};
    logic [7:0]  cpu_ids [MAX_CPUS] = '{default: '0};
    int          n_cpus, n_ioapics;
    logic [3:0]  err_code = STAT_OK;
    bit          tbl_open;

    // bookkeeping
    int        cycle_cnt, mismatches, results_seen, bytes_in;
    int        bytes_queued, tables_sent, cfg_writes;
    madt_out_t next_want;

    function automatic logic [31:0] buf_le32(input int at);
        return {rec_buf[at + 3], rec_buf[at + 2], rec_buf[at + 1], rec_buf[at]};
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [7:0] id,
                                 input logic [31:0] base, input logic [31:0] gsi,
                                 input logic [3:0] src, input logic [15:0] flg,
                                 input logic [3:0] st, input logic fin);
        madt_out_t r;
        r.record_kind    = kind;
        r.controller_id  = id;
        r.base_address   = base;
        r.interrupt_base = gsi;
        r.isa_source     = src;
        r.isa_flags      = flg;
        r.status         = st;
        r.cpu_count      = 7'(n_cpus);
        r.ioapic_count   = 4'(n_ioapics);
        r.final_result   = fin;
        parsed_items.push_back(r);
    endfunction

    function automatic logic [3:0] enroll_cpu(input logic [31:0] id);
        if (id > 255) return STAT_ID_RANGE;
        for (int i = 0; i < n_cpus; i++)
            if (cpu_ids[i] == id[7:0]) return STAT_DUP_ID;
        if (n_cpus >= MAX_CPUS) return STAT_TOO_MANY;
        cpu_ids[n_cpus] = id[7:0];
        n_cpus++;
        return STAT_OK;
    endfunction

    function automatic void close_record();
        logic [31:0] w4, w8;
        w4 = buf_le32(4);
        w8 = buf_le32(8);
        if (rec_type == REC_LAPIC && rec_len >= LEN_LAPIC) begin
            if (w4[1:0] != 2'b00) begin
                err_code = enroll_cpu({24'h0, rec_buf[3]});
                if (err_code == STAT_OK)
                    emit(KIND_CPU, rec_buf[3], '0, '0, '0, '0, STAT_OK, 1'b0);
            end
        end else if (rec_type == REC_IOAPIC && rec_len >= LEN_IOAPIC) begin
            // io apics past the limit vanish without an error
            if (n_ioapics < MAX_IOAPICS) begin
                n_ioapics++;
                emit(KIND_IOAPIC, rec_buf[2], w4, w8, '0, '0, STAT_OK, 1'b0);
            end
        end else if (rec_type == REC_ISO && rec_len >= LEN_ISO) begin
            if (rec_buf[2] == 8'h00 && rec_buf[3] < 16)
                emit(KIND_ISA, '0, '0, w4, rec_buf[3][3:0], {rec_buf[9], rec_buf[8]},
                     STAT_OK, 1'b0);
        end else if (rec_type == REC_LAPIC_OVR && rec_len >= LEN_LAPIC_OVR) begin
            if (w8 != '0) begin
                err_code = STAT_OVR_WIDE;
            end else begin
                lapic_now = w4;
                emit(KIND_LAPIC, '0, w4, '0, '0, '0, STAT_OK, 1'b0);
            end
        end else if (rec_type == REC_X2APIC && rec_len >= LEN_X2APIC) begin
            if (w8[1:0] != 2'b00) begin
                err_code = enroll_cpu(w4);
                if (err_code == STAT_OK)
                    emit(KIND_CPU, w4[7:0], '0, '0, '0, '0, STAT_OK, 1'b0);
            end
        end
    endfunction

    function automatic void parse_byte(input madt_in_t it);
        logic [7:0] b;
        logic       eot, done;
        b    = it.data_byte;
        eot  = it.end_of_table;
        done = 1'b0;
        // first byte of a table picks up the header address and clears counts
        if (!tbl_open) begin
            tbl_open  = 1'b1;
            lapic_now = hdr_lapic;
            n_cpus    = 0;
            n_ioapics = 0;
            err_code  = STAT_OK;
            rec_off   = '0;
        end
        if (err_code == STAT_OK) begin
            if (rec_off < HOLD_BYTES) rec_buf[rec_off[3:0]] = b;
            if (rec_off == 0) begin
                rec_type = b;
                if (eot) err_code = STAT_TRUNC_HDR;
            end else if (rec_off == 1) begin
                rec_len = b;
                if (b < 2) err_code = STAT_SHORT_LEN;
                else if (b == 2) done = 1'b1;
                else if (eot) err_code = STAT_OVERRUN;
            end else begin
                if (rec_off + 1 == rec_len) done = 1'b1;
                else if (eot) err_code = STAT_OVERRUN;
            end
            if (done) begin
                rec_off = '0;
                close_record();
            end else if (err_code == STAT_OK) begin
                rec_off = rec_off + 8'd1;
            end
        end
        if (eot) begin
            if (err_code == STAT_OK && (n_cpus == 0 || n_ioapics == 0 || lapic_now == '0))
                err_code = STAT_NO_TOPO;
            emit(KIND_FINAL, '0, lapic_now, '0, '0, '0, err_code, 1'b1);
            tbl_open = 1'b0;
            rec_off  = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MISMATCH_PRINTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_seen, field, got, want));
    endtask

    // sender: an idle gap is drawn after every accepted item when src_idle is set
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (s_took) src_gap = src_idle ? $urandom_range(0, 14) : 0;
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (body_bytes.size() > 0) begin
                s_data  <= body_bytes.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: per-item stall, plus a long hold-off when one is asked for
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end else if (m_took) begin
                sink_gap = snk_idle ? $urandom_range(0, 14) : 0;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end
            m_ready <= (hold_left == 0) && (sink_gap == 0);
        end
    end

    // accepted bytes go through the local parser
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                parse_byte(s_data);
                bytes_in++;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, parsed_items.size());
            $display("Some tests failed");
            $finish;
        end else if (!aresetn) begin
            m_took <= 1'b0;
        end else begin
            m_took <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                if (parsed_items.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              results_seen));
                end else begin
                    next_want = parsed_items.pop_front();
                    check_field("record_kind", m_data.record_kind, next_want.record_kind);
                    check_field("controller_id", m_data.controller_id,
                                next_want.controller_id);
                    check_field("base_address", m_data.base_address,
                                next_want.base_address);
                    check_field("interrupt_base", m_data.interrupt_base,
                                next_want.interrupt_base);
                    check_field("isa_source", m_data.isa_source, next_want.isa_source);
                    check_field("isa_flags", m_data.isa_flags, next_want.isa_flags);
                    check_field("status", m_data.status, next_want.status);
                    check_field("cpu_count", m_data.cpu_count, next_want.cpu_count);
                    check_field("ioapic_count", m_data.ioapic_count,
                                next_want.ioapic_count);
                    check_field("final_result", m_data.final_result,
                                next_want.final_result);
                end
            end
        end
    end

    // table building
    task automatic open_rec(input logic [7:0] kind, input logic [7:0] len);
        rec_start = table_body.size();
        table_body.push_back(kind);
        table_body.push_back(len);
    endtask

    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) table_body.push_back(v[8 * i +: 8]);
    endtask

    task automatic add_lapic(input logic [7:0] id, input logic [31:0] flags);
        open_rec(REC_LAPIC, LEN_LAPIC);
        table_body.push_back(8'($urandom_range(0, 255)));
        table_body.push_back(id);
        put_le(flags, 4);
    endtask

    task automatic add_x2apic(input logic [31:0] id, input logic [31:0] flags);
        open_rec(REC_X2APIC, LEN_X2APIC);
        put_le(16'($urandom), 2);
        put_le(id, 4);
        put_le(flags, 4);
        put_le($urandom, 4);
    endtask

    task automatic add_ioapic(input logic [7:0] id, input logic [31:0] addr,
                              input logic [31:0] gsi);
        open_rec(REC_IOAPIC, LEN_IOAPIC);
        table_body.push_back(id);
        table_body.push_back(8'($urandom_range(0, 255)));
        put_le(addr, 4);
        put_le(gsi, 4);
    endtask

    task automatic add_iso(input logic [7:0] bus, input logic [7:0] src,
                           input logic [31:0] gsi, input logic [15:0] flags);
        open_rec(REC_ISO, LEN_ISO);
        table_body.push_back(bus);
        table_body.push_back(src);
        put_le(gsi, 4);
        put_le(flags, 2);
    endtask

    task automatic add_lapic_ovr(input logic [63:0] addr);
        open_rec(REC_LAPIC_OVR, LEN_LAPIC_OVR);
        put_le(16'($urandom), 2);
        put_le(addr, 8);
    endtask

    task automatic add_raw(input logic [7:0] kind, input logic [7:0] len);
        open_rec(kind, len);
        for (int i = 2; i < len; i++) table_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // stretch the last record with trailing bytes the parser must skip
    task automatic pad_last(input int n);
        table_body[rec_start + 1] = table_body[rec_start + 1] + 8'(n);
        repeat (n) table_body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic ship(input bit close);
        madt_in_t it;
        for (int i = 0; i < table_body.size(); i++) begin
            it.data_byte    = table_body[i];
            it.end_of_table = close && (i == table_body.size() - 1);
            body_bytes.push_back(it);
        end
        bytes_queued += table_body.size();
        if (close) tables_sent++;
        table_body.delete();
    endtask

    // wait for the sender to run dry and every result to come back, then redraw the stall modes
    task automatic drain();
        while (body_bytes.size() != 0 || s_valid || parsed_items.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        {src_idle, snk_idle} = 2'($urandom_range(0, 3));
    endtask

    task automatic set_header_lapic(input logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        hdr_lapic = v;
        cfg_writes++;
    endtask

    function automatic logic [7:0] rand_id();
        // a narrow pool now and then so duplicates turn up
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_table();
        int         n_recs, shape, pick, keep;
        logic [31:0] flg;
        logic [63:0] ovr;
        n_recs = $urandom_range(1, 8);
        shape  = $urandom_range(0, 99);
        if (shape < 5) begin
            repeat ($urandom_range(1, 24)) table_body.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (shape >= 50) begin
                add_lapic(rand_id(), 32'h1);
                add_ioapic(8'($urandom_range(0, 255)), $urandom, $urandom);
            end
            for (int k = 0; k < n_recs; k++) begin
                pick = $urandom_range(0, 99);
                flg  = $urandom;
                if ($urandom_range(0, 6) == 0) flg[1:0] = 2'b00;
                if (pick < 30) begin
                    add_lapic(rand_id(), flg);
                end else if (pick < 42) begin
                    add_x2apic(($urandom_range(0, 9) == 0) ? $urandom : {24'h0, rand_id()}, flg);
                end else if (pick < 62) begin
                    add_ioapic(8'($urandom_range(0, 255)), $urandom, $urandom);
                end else if (pick < 74) begin
                    add_iso(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                            ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                                        : 8'($urandom_range(0, 15)),
                            $urandom, 16'($urandom));
                end else if (pick < 80) begin
                    ovr[31:0]  = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
                    ovr[63:32] = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0;
                    add_lapic_ovr(ovr);
                end else if (pick < 88) begin
                    add_raw(8'($urandom_range(0, 255)), 8'($urandom_range(2, 20)));
                end else begin
                    // known type, too short to decode
                    case ($urandom_range(0, 4))
                        0: add_raw(REC_LAPIC, 8'($urandom_range(2, LEN_LAPIC - 1)));
                        1: add_raw(REC_IOAPIC, 8'($urandom_range(2, LEN_IOAPIC - 1)));
                        2: add_raw(REC_ISO, 8'($urandom_range(2, LEN_ISO - 1)));
                        3: add_raw(REC_LAPIC_OVR, 8'($urandom_range(2, LEN_LAPIC_OVR - 1)));
                        default: add_raw(REC_X2APIC, 8'($urandom_range(2, LEN_X2APIC - 1)));
                    endcase
                end
                if ($urandom_range(0, 4) == 0) pad_last($urandom_range(1, 8));
            end
            // cut the body short so the end mark can land inside a record
            if (shape < 11) begin
                keep = $urandom_range(1, table_body.size());
                while (table_body.size() > keep) void'(table_body.pop_back());
            end
        end
        ship(1'b1);
    endtask

    initial begin
        int directed_bytes;
        {src_idle, snk_idle} = 2'b11;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_header_lapic(32'hFEE0_0000);

        // every record kind, field extremes and the ignored variants
        add_lapic(8'h00, 32'h1);
        add_x2apic(32'd255, 32'h2);
        add_ioapic(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_ioapic(8'h00, 32'h0, 32'h0);
        add_iso(8'h00, 8'd15, 32'h0, 16'hFFFF);
        add_iso(8'h00, 8'd0, 32'hFFFF_FFFF, 16'h0000);
        add_iso(8'h01, 8'd3, 32'd5, 16'h0005);
        add_iso(8'h00, 8'd16, 32'd9, 16'h000F);
        add_lapic(8'h07, 32'hFFFF_FFFC);
        add_x2apic(32'd300, 32'h0);
        add_raw(8'hFF, 8'd3);
        add_raw(REC_LAPIC, 8'd2);
        add_raw(REC_IOAPIC, 8'd11);
        add_raw(REC_X2APIC, 8'd15);
        add_lapic(8'h01, 32'h3);
        pad_last(247);
        // a record closing on the end mark gives two results for one byte
        add_lapic_ovr(64'h0000_0000_FFFF_FFFF);
        ship(1'b1);

        // end mark on a type byte
        table_body.push_back(REC_LAPIC);
        ship(1'b1);
        // length below two, then ignored bytes
        add_raw(REC_LAPIC, 8'd1);
        repeat (2) table_body.push_back(8'($urandom_range(0, 255)));
        ship(1'b1);
        add_raw(REC_IOAPIC, 8'd0);
        ship(1'b1);
        // record overruns, inside the body and on the length byte
        open_rec(REC_LAPIC, LEN_LAPIC);
        table_body.push_back(8'h01);
        table_body.push_back(8'h02);
        ship(1'b1);
        open_rec(REC_IOAPIC, LEN_IOAPIC);
        ship(1'b1);
        // id out of range, duplicate, override too wide
        add_lapic(8'h01, 32'h1);
        add_x2apic(32'd256, 32'h1);
        add_ioapic(8'h02, 32'hFEC0_0000, 32'h0);
        ship(1'b1);
        add_lapic(8'h05, 32'h1);
        add_ioapic(8'h02, 32'hFEC0_0000, 32'h0);
        add_x2apic(32'd5, 32'h1);
        ship(1'b1);
        add_lapic(8'h03, 32'h1);
        add_lapic_ovr(64'h1_0000_0000);
        ship(1'b1);
        // missing topology: no cpu, no io apic, address overridden to zero, bare record
        add_ioapic(8'h01, 32'hFEC0_0000, 32'h0);
        ship(1'b1);
        add_lapic(8'h04, 32'h1);
        ship(1'b1);
        add_lapic(8'h04, 32'h1);
        add_ioapic(8'h01, 32'hFEC0_0000, 32'h0);
        add_lapic_ovr(64'h0);
        ship(1'b1);
        add_raw(8'h44, 8'd2);
        ship(1'b1);
        drain();

        // zero header address, then a write in the middle of a table
        set_header_lapic(32'h0);
        add_lapic(8'h08, 32'h1);
        add_ioapic(8'h01, 32'hFEC0_0000, 32'h0);
        ship(1'b1);
        add_lapic(8'h09, 32'h1);
        ship(1'b0);
        drain();
        set_header_lapic(32'hFFFF_FFFF);
        add_ioapic(8'h01, 32'hFEC0_0000, 32'h0);
        ship(1'b1);
        add_lapic(8'h09, 32'h1);
        add_ioapic(8'h01, 32'hFEC0_0000, 32'h0);
        ship(1'b1);

        // io apic limit, then the cpu limit on the 65th processor
        for (int i = 0; i <= MAX_IOAPICS; i++)
            add_ioapic(8'(i), 32'hFEC0_0000 + 32'(i << 12), 32'(i * 24));
        for (int i = 0; i <= MAX_CPUS; i++) add_lapic(8'(i), 32'h1);
        ship(1'b1);
        drain();
        set_header_lapic(32'hFEE0_0000);
        directed_bytes = bytes_queued;

        // long sink hold-off while the source keeps offering
        hold_asked++;
        repeat (4) random_table();

        while (bytes_queued - directed_bytes < RANDOM_BYTES) begin
            random_table();
            if (tables_sent % 8 == 0) begin
                drain();
                case ($urandom_range(0, 4))
                    0: set_header_lapic(32'h0);
                    1: set_header_lapic(32'hFFFF_FFFF);
                    2: set_header_lapic($urandom);
                    default: ;
                endcase
            end
        end
        drain();

        $display("checked %0d results from %0d body bytes in %0d tables, %0d header writes",
                 results_seen, bytes_in, tables_sent, cfg_writes);
        $display("directed tables hit each status code; random tables mixed records, "
                 + "cut-off bodies and noise under source and sink stalls");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
